// ===== rtl/imaenc_pkg.sv =====
// ----------------------------------------------------------------------------
// imaenc_pkg
// Shared types, constants and table functions for the IMA ADPCM encoder.
// ----------------------------------------------------------------------------
package imaenc_pkg;

    localparam int unsigned POS_W    = 7;
    localparam int unsigned STEP_W   = 15;
    localparam int unsigned SMP_W    = 16;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_MAX  = 88;
    localparam int unsigned STEP_CNT = 89;

    localparam logic [0:0] ACT_ENCODE = 1'b0;
    localparam logic [0:0] ACT_CLEAR  = 1'b1;

    // standard 89-entry step size table
    localparam logic [STEP_W-1:0] STEP_TAB [0:STEP_CNT-1] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
        15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
        15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
        15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
        15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
        15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
        15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
        15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // index adjustment per 3-bit magnitude
    localparam logic signed [4:0] IDX_ADJ [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    // control from the encode stage to the packer
    typedef struct packed {
        logic fire;
        logic clear;
        logic last;
    } t_pack_ctl;

    // step size lookup, positions past the top read the top entry
    function automatic logic [STEP_W-1:0] step_size(input logic [POS_W-1:0] pos);
        logic [STEP_W-1:0] res;
        if (pos > POS_W'(POS_MAX)) begin
            res = STEP_TAB[POS_MAX];
        end else begin
            res = STEP_TAB[pos];
        end
        return res;
    endfunction

endpackage

// ===== rtl/ima_adpcm_encoder_packer_top.sv =====
// ----------------------------------------------------------------------------
// ima_adpcm_encoder_packer_top
// IMA ADPCM 4-bit encoder with two-codes-per-byte packer.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit sample per beat and encodes it into a 4-bit
// IMA ADPCM code; two codes form one output byte, the earlier in the low
// nibble, and a last sample with no partner goes out with a zero high
// nibble. Action 1 clears predictor, step index and the held nibble. One
// beat is taken every cycle unless the input stalls: a sample sits in the
// input register while the step lookup, compare-subtract chain and
// predictor update run, and any finished byte is written to the output
// register as the beat leaves the input register. While an output
// byte is stalled the input register holds its beat, whatever it is, and
// the input stalls once that register is occupied.
module ima_adpcm_encoder_packer_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_action,
    input  logic signed [imaenc_pkg::SMP_W-1:0]   i_sample,
    input  logic                                  i_last_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic        [imaenc_pkg::BYTE_W-1:0]  o_packed_byte
);

    logic                                r_in_valid;
    logic                                r_action;
    logic signed [imaenc_pkg::SMP_W-1:0] r_sample;
    logic                                r_last;
    logic signed [imaenc_pkg::SMP_W-1:0] r_pred;
    logic        [imaenc_pkg::POS_W-1:0] r_pos;
    logic signed [imaenc_pkg::SMP_W-1:0] n_pred;
    logic        [imaenc_pkg::POS_W-1:0] n_pos;
    logic        [imaenc_pkg::NIB_W-1:0] code;
    logic                                busy;
    logic                                adv;
    logic                                accept;
    imaenc_pkg::t_pack_ctl               pack_ctl;

    // handshake
    assign adv     = r_in_valid && !busy;
    assign o_stall = r_in_valid && busy;
    assign accept  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_sample <= i_sample;
            r_last   <= i_last_sample;
        end
    end

    // encoder datapath
    imaenc_quant u_quant (
        .i_sample (r_sample),
        .i_pred   (r_pred),
        .i_pos    (r_pos),
        .o_code   (code),
        .o_pred   (n_pred),
        .o_pos    (n_pos)
    );

    // predictor and step position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred <= '0;
            r_pos  <= '0;
        end else if (adv) begin
            if (r_action == imaenc_pkg::ACT_CLEAR) begin
                r_pred <= '0;
                r_pos  <= '0;
            end else begin
                r_pred <= n_pred;
                r_pos  <= n_pos;
            end
        end
    end

    // packer control
    always_comb begin
        pack_ctl.fire  = adv && (r_action == imaenc_pkg::ACT_ENCODE);
        pack_ctl.clear = adv && (r_action == imaenc_pkg::ACT_CLEAR);
        pack_ctl.last  = r_last;
    end

    imaenc_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (pack_ctl),
        .i_code        (code),
        .i_stall       (i_stall),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_packed_byte (o_packed_byte)
    );

endmodule

// ===== rtl/imaenc_quant.sv =====
// ----------------------------------------------------------------------------
// imaenc_quant
// Quantizes one sample against the predictor and step size, and computes
// the next predictor and step position.
// ----------------------------------------------------------------------------
module imaenc_quant (
    input  logic signed [imaenc_pkg::SMP_W-1:0] i_sample,
    input  logic signed [imaenc_pkg::SMP_W-1:0] i_pred,
    input  logic        [imaenc_pkg::POS_W-1:0] i_pos,
    output logic        [imaenc_pkg::NIB_W-1:0] o_code,
    output logic signed [imaenc_pkg::SMP_W-1:0] o_pred,
    output logic        [imaenc_pkg::POS_W-1:0] o_pos
);

    logic [imaenc_pkg::STEP_W-1:0] step;
    logic signed [16:0]            diff;
    logic                          sign;
    logic [16:0]                   mag_a;
    logic [16:0]                   mag_b;
    logic [16:0]                   mag_c;
    logic [2:0]                    mag;
    logic [16:0]                   dq;
    logic signed [17:0]            psum;
    logic signed [7:0]             npos;

    // difference and its magnitude
    always_comb begin
        step  = imaenc_pkg::step_size(i_pos);
        diff  = 17'(i_sample) - 17'(i_pred);
        sign  = diff[16];
        mag_a = sign ? 17'(-diff) : 17'(diff);
    end

    // three compare-subtract steps
    always_comb begin
        mag[2] = (mag_a >= 17'(step));
        mag_b  = mag[2] ? (mag_a - 17'(step)) : mag_a;
        mag[1] = (mag_b >= 17'(step >> 1));
        mag_c  = mag[1] ? (mag_b - 17'(step >> 1)) : mag_b;
        mag[0] = (mag_c >= 17'(step >> 2));
    end

    // reconstructed difference and saturated predictor
    always_comb begin
        dq = 17'(step >> 3);
        if (mag[2]) dq = dq + 17'(step);
        if (mag[1]) dq = dq + 17'(step >> 1);
        if (mag[0]) dq = dq + 17'(step >> 2);
        psum = sign ? (18'(i_pred) - $signed({1'b0, dq}))
                    : (18'(i_pred) + $signed({1'b0, dq}));
        if (psum > 18'sd32767) begin
            o_pred = 16'sh7FFF;
        end else if (psum < -18'sd32768) begin
            o_pred = 16'sh8000;
        end else begin
            o_pred = psum[15:0];
        end
    end

    // step position update with clamp
    always_comb begin
        npos = $signed({1'b0, i_pos}) + 8'(imaenc_pkg::IDX_ADJ[mag]);
        if (npos < 8'sd0) begin
            o_pos = '0;
        end else if (npos > 8'(imaenc_pkg::POS_MAX)) begin
            o_pos = imaenc_pkg::POS_W'(imaenc_pkg::POS_MAX);
        end else begin
            o_pos = npos[imaenc_pkg::POS_W-1:0];
        end
        o_code = {sign, mag};
    end

endmodule

// ===== rtl/imaenc_pack.sv =====
// ----------------------------------------------------------------------------
// imaenc_pack
// Pairs 4-bit codes into bytes and holds the output register.
// ----------------------------------------------------------------------------
module imaenc_pack (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  imaenc_pkg::t_pack_ctl               i_ctl,
    input  logic [imaenc_pkg::NIB_W-1:0]        i_code,
    input  logic                                i_stall,
    output logic                                o_busy,
    output logic                                o_valid,
    output logic [imaenc_pkg::BYTE_W-1:0]       o_packed_byte
);

    logic                                r_pending;
    logic [imaenc_pkg::NIB_W-1:0]        r_held;
    logic                                r_out_valid;
    logic [imaenc_pkg::BYTE_W-1:0]       r_out_byte;
    logic                                n_pending;
    logic [imaenc_pkg::NIB_W-1:0]        n_held;
    logic                                emit;
    logic [imaenc_pkg::BYTE_W-1:0]       emit_byte;

    // pairing decision
    always_comb begin
        n_pending = r_pending;
        n_held    = r_held;
        emit      = 1'b0;
        emit_byte = {i_code, r_held};
        if (i_ctl.clear) begin
            n_pending = 1'b0;
            n_held    = '0;
        end else if (i_ctl.fire) begin
            if (r_pending) begin
                emit      = 1'b1;
                n_pending = 1'b0;
                n_held    = '0;
            end else if (i_ctl.last) begin
                emit      = 1'b1;
                emit_byte = {{imaenc_pkg::NIB_W{1'b0}}, i_code};
            end else begin
                n_pending = 1'b1;
                n_held    = i_code;
            end
        end
    end

    // nibble state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_held    <= '0;
        end else begin
            r_pending <= n_pending;
            r_held    <= n_held;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= emit_byte;
        end
    end

    assign o_busy        = r_out_valid && i_stall;
    assign o_valid       = r_out_valid;
    assign o_packed_byte = r_out_byte;

endmodule
